### hdl/midi_timecode_quarter_frame_parser_macros.svh
`ifndef MIDI_TIMECODE_QUARTER_FRAME_PARSER_MACROS_SVH
`define MIDI_TIMECODE_QUARTER_FRAME_PARSER_MACROS_SVH

// Assertion checked on every rising edge of clk outside reset.
`define MTCQF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion checked on every rising edge of clk, reset included.
`define MTCQF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/mtcqf_pkg.sv
package mtcqf_pkg;

  localparam logic [31:0] SYNC_TIMEOUT_RESET = 32'd500000;

  typedef enum logic [1:0] {
    REQ_QUARTER = 2'd0,
    REQ_FULL    = 2'd1,
    REQ_POLL    = 2'd2
  } req_e_t;

  typedef enum logic [1:0] {
    RATE_24    = 2'd0,
    RATE_25    = 2'd1,
    RATE_30DF  = 2'd2,
    RATE_30    = 2'd3
  } rate_e_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [6:0]  qf_byte;
    logic [6:0]  full_hour_byte;
    logic [6:0]  full_minute;
    logic [6:0]  full_second;
    logic [6:0]  full_frame;
    logic [31:0] stamp_us;
  } in_item_t;

  typedef struct packed {
    logic       event_res;
    logic       time_valid;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [4:0] frame;
    logic [1:0] rate_type;
  } out_item_t;

  typedef struct packed {
    logic [7:0][3:0] nib;
    logic [2:0]      prev;
    logic            prev_seen;
    logic            valid;
    logic            moving;
    logic            fwd;
    logic [31:0]     last_stamp;
    logic [4:0]      hour;
    logic [5:0]      minute;
    logic [5:0]      second;
    logic [4:0]      frame;
    logic [1:0]      rate;
  } mtc_state_t;

  function automatic logic [4:0] frame_limit(input logic [1:0] rate);
    logic [4:0] lim;
    case (rate_e_t'(rate))
      RATE_24: lim = 5'd24;
      RATE_25: lim = 5'd25;
      default: lim = 5'd30;
    endcase
    return lim;
  endfunction

  function automatic logic time_in_range(input logic [6:0] h, input logic [6:0] m,
                                         input logic [6:0] s, input logic [6:0] f,
                                         input logic [1:0] rate);
    return (h < 7'd24) && (m < 7'd60) && (s < 7'd60) && (f < {2'b00, frame_limit(rate)});
  endfunction

endpackage

### hdl/mtcqf_step.sv
module mtcqf_step (
  input  mtcqf_pkg::mtc_state_t st,
  input  mtcqf_pkg::in_item_t   item,
  input  logic [31:0]           sync_timeout,
  output mtcqf_pkg::mtc_state_t st_nxt,
  output mtcqf_pkg::out_item_t  res
);
  import mtcqf_pkg::*;

  logic [7:0][3:0] nib;
  logic [2:0]      n;
  logic [2:0]      prev_inc;
  logic [2:0]      n_inc;
  logic [31:0]     since;
  logic            full_ok;
  logic            ev;

  assign n        = item.qf_byte[6:4];
  assign prev_inc = st.prev + 3'd1;
  assign n_inc    = n + 3'd1;
  assign since    = item.stamp_us - st.last_stamp;
  assign full_ok  = time_in_range({2'b00, item.full_hour_byte[4:0]}, item.full_minute,
                                  item.full_second, item.full_frame,
                                  item.full_hour_byte[6:5]);

  always_comb begin
    st_nxt = st;
    nib    = st.nib;
    ev     = 1'b0;
    case (req_e_t'(item.req_type))
      REQ_QUARTER: begin
        nib[n] = item.qf_byte[3:0];
        st_nxt.last_stamp = item.stamp_us;
        if (st.prev_seen) begin
          if (n == prev_inc) begin
            st_nxt.fwd    = 1'b1;
            st_nxt.moving = 1'b1;
          end else if (st.prev == n_inc) begin
            st_nxt.fwd    = 1'b0;
            st_nxt.moving = 1'b1;
          end else begin
            st_nxt.fwd    = 1'b0;
            st_nxt.moving = 1'b0;
          end
        end
        st_nxt.prev      = n;
        st_nxt.prev_seen = 1'b1;
        st_nxt.nib       = nib;
        st_nxt.frame     = {nib[1][0], nib[0]};
        st_nxt.second    = {nib[3][1:0], nib[2]};
        st_nxt.minute    = {nib[5][1:0], nib[4]};
        st_nxt.hour      = {nib[7][0], nib[6]};
        st_nxt.rate      = nib[7][2:1];
        st_nxt.valid     = time_in_range({2'b00, st_nxt.hour}, {1'b0, st_nxt.minute},
                                         {1'b0, st_nxt.second}, {2'b00, st_nxt.frame},
                                         st_nxt.rate);
        ev = st_nxt.moving && st_nxt.valid &&
             ((st_nxt.fwd && (n == 3'd7)) || (!st_nxt.fwd && (n == 3'd0)));
      end
      REQ_FULL: begin
        st_nxt.last_stamp = item.stamp_us;
        st_nxt.rate       = item.full_hour_byte[6:5];
        st_nxt.hour       = item.full_hour_byte[4:0];
        st_nxt.minute     = item.full_minute[5:0];
        st_nxt.second     = item.full_second[5:0];
        st_nxt.frame      = item.full_frame[4:0];
        st_nxt.valid      = full_ok;
        st_nxt.fwd        = 1'b0;
        st_nxt.moving     = 1'b0;
        st_nxt.prev_seen  = 1'b0;
        st_nxt.prev       = 3'd0;
        if (full_ok) begin
          st_nxt.nib[0] = item.full_frame[3:0];
          st_nxt.nib[1] = {1'b0, item.full_frame[6:4]};
          st_nxt.nib[2] = item.full_second[3:0];
          st_nxt.nib[3] = {1'b0, item.full_second[6:4]};
          st_nxt.nib[4] = item.full_minute[3:0];
          st_nxt.nib[5] = {1'b0, item.full_minute[6:4]};
          st_nxt.nib[6] = item.full_hour_byte[3:0];
          st_nxt.nib[7] = {1'b0, item.full_hour_byte[6:5], item.full_hour_byte[4]};
        end
        ev = full_ok;
      end
      REQ_POLL: begin
        if (st.valid && (since > sync_timeout)) begin
          st_nxt.valid  = 1'b0;
          st_nxt.moving = 1'b0;
          st_nxt.fwd    = 1'b0;
          ev = 1'b1;
        end
      end
      default: begin
        ev = 1'b0;
      end
    endcase
  end

  always_comb begin
    res            = '0;
    res.event_res  = ev;
    res.time_valid = st_nxt.valid;
    if (st_nxt.valid) begin
      res.hour      = st_nxt.hour;
      res.minute    = st_nxt.minute;
      res.second    = st_nxt.second;
      res.frame     = st_nxt.frame;
      res.rate_type = st_nxt.rate;
    end
  end

endmodule

### hdl/midi_timecode_quarter_frame_parser.sv
// MIDI time code quarter-frame parser.
// The input channel (in_valid, in_stall, in_data) carries quarter-frame bytes, full-frame
// times and poll ticks, each with a microsecond stamp. A transfer happens at a rising edge
// with valid high and stall low. Every input transfer yields exactly one result transfer
// on the output channel (out_valid, out_stall, out_data), in order.
// An input transfer is captured in the input register; the item then goes through the
// parser logic into the result register, where the state is also updated, and out_valid
// rises with it. Throughput is one item per cycle while the receiver does not stall,
// set by the single update of the state registers per item. The sync timeout must be
// written through cfg_wr_en and cfg_wr_data while the block is idle; it is not enforced.
// A synchronous active-low reset clears the nibbles, flags and stamp, empties both
// registers and sets the timeout to 500000 microseconds.
// When the receiver stalls, the result register holds its transfer; the input register,
// if empty, still takes one more item, and then in_stall rises until the result is taken.
module midi_timecode_quarter_frame_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mtcqf_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mtcqf_pkg::out_item_t out_data,
  input  logic                 cfg_wr_en,
  input  logic [31:0]          cfg_wr_data
);
  import mtcqf_pkg::*;

  logic       in_valid_r;
  in_item_t   in_data_r;
  logic       out_valid_r;
  out_item_t  out_data_r;
  mtc_state_t state_r;
  mtc_state_t state_nxt;
  out_item_t  res_nxt;
  logic [31:0] timeout_r;
  logic       advance;
  logic       in_take;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  mtcqf_step u_step (
    .st           (state_r),
    .item         (in_data_r),
    .sync_timeout (timeout_r),
    .st_nxt       (state_nxt),
    .res          (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
      timeout_r   <= SYNC_TIMEOUT_RESET;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
        if (in_valid_r) begin
          state_r <= state_nxt;
        end
      end
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
    if (advance && in_valid_r) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hdl/mtcqf_checker.sv
`include "midi_timecode_quarter_frame_parser_macros.svh"

module mtcqf_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input mtcqf_pkg::out_item_t out_data
);
  import mtcqf_pkg::*;

  `MTCQF_ASSERT(a_out_hold,
    out_valid && out_stall |=> out_valid && $stable(out_data),
    "stalled result changed")
  `MTCQF_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result present after reset")
  `MTCQF_ASSERT_ALWAYS(a_no_stall_when_empty,
    !out_valid |-> !in_stall,
    "input stalled with empty output")
  `MTCQF_ASSERT(a_invalid_zero,
    out_valid && !out_data.time_valid |-> out_data.hour == 5'd0 &&
      out_data.minute == 6'd0 && out_data.second == 6'd0 &&
      out_data.frame == 5'd0 && out_data.rate_type == 2'd0,
    "invalid time not zeroed")
  `MTCQF_ASSERT(a_valid_range,
    out_valid && out_data.time_valid |-> out_data.hour < 5'd24 &&
      out_data.minute < 6'd60 && out_data.second < 6'd60 &&
      out_data.frame < frame_limit(out_data.rate_type),
    "valid time out of range")

endmodule

bind midi_timecode_quarter_frame_parser mtcqf_checker u_mtcqf_checker (.*);

### sim/mtc_timecode_checker.sv
module mtc_timecode_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  mtcqf_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  mtcqf_pkg::out_item_t out_data,
  input  logic                 cfg_wr_en,
  input  logic [31:0]          cfg_wr_data,
  output int                   mismatch_count,
  output int                   results_awaited
);
  timeunit 1ns;
  timeprecision 1ps;
  import mtcqf_pkg::*;

  localparam logic [2:0] NIB_FIRST = 3'd0;
  localparam logic [2:0] NIB_LAST  = 3'd7;

  logic [3:0]  nib [8];
  logic [2:0]  prev_nib;
  logic        prev_seen;
  logic        time_valid;
  logic        moving;
  logic        forward;
  logic [31:0] last_frame_us;
  logic [4:0]  held_hour;
  logic [6:0]  held_minute;
  logic [6:0]  held_second;
  logic [6:0]  held_frame;
  logic [1:0]  held_rate;
  logic [31:0] timeout_us;

  out_item_t awaited_results [$];

  function automatic logic time_ok(input logic [4:0] h, input logic [6:0] m,
                                   input logic [6:0] s, input logic [6:0] f,
                                   input logic [1:0] r);
    logic [6:0] fps;
    case (rate_e_t'(r))
      RATE_24: fps = 7'd24;
      RATE_25: fps = 7'd25;
      default: fps = 7'd30;
    endcase
    return (h < 5'd24) && (m < 7'd60) && (s < 7'd60) && (f < fps);
  endfunction

  task automatic advance_timecode(input in_item_t it, output out_item_t res);
    logic [2:0]  n;
    logic        ev;
    logic [31:0] since;
    ev = 1'b0;
    case (it.req_type)
      REQ_QUARTER: begin
        n = it.qf_byte[6:4];
        nib[n] = it.qf_byte[3:0];
        last_frame_us = it.stamp_us;
        if (prev_seen) begin
          if (n == prev_nib + 3'd1) begin
            forward = 1'b1;
            moving  = 1'b1;
          end else if (prev_nib == n + 3'd1) begin
            forward = 1'b0;
            moving  = 1'b1;
          end else begin
            forward = 1'b0;
            moving  = 1'b0;
          end
        end
        prev_nib    = n;
        prev_seen   = 1'b1;
        held_frame  = {2'b00, nib[1][0], nib[0]};
        held_second = {1'b0, nib[3][1:0], nib[2]};
        held_minute = {1'b0, nib[5][1:0], nib[4]};
        held_hour   = {nib[7][0], nib[6]};
        held_rate   = nib[7][2:1];
        time_valid  = time_ok(held_hour, held_minute, held_second, held_frame, held_rate);
        if (moving && time_valid &&
            ((forward && n == NIB_LAST) || (!forward && n == NIB_FIRST))) begin
          ev = 1'b1;
        end
      end
      REQ_FULL: begin
        last_frame_us = it.stamp_us;
        held_rate     = it.full_hour_byte[6:5];
        held_hour     = it.full_hour_byte[4:0];
        held_minute   = it.full_minute;
        held_second   = it.full_second;
        held_frame    = it.full_frame;
        time_valid    = time_ok(held_hour, held_minute, held_second, held_frame, held_rate);
        forward       = 1'b0;
        moving        = 1'b0;
        prev_seen     = 1'b0;
        prev_nib      = NIB_FIRST;
        if (time_valid) begin
          nib[0] = held_frame[3:0];
          nib[1] = {1'b0, held_frame[6:4]};
          nib[2] = held_second[3:0];
          nib[3] = {1'b0, held_second[6:4]};
          nib[4] = held_minute[3:0];
          nib[5] = {1'b0, held_minute[6:4]};
          nib[6] = held_hour[3:0];
          nib[7] = {1'b0, held_rate, held_hour[4]};
        end
        ev = time_valid;
      end
      REQ_POLL: begin
        if (time_valid) begin
          since = it.stamp_us - last_frame_us;
          if (since > timeout_us) begin
            time_valid = 1'b0;
            moving     = 1'b0;
            forward    = 1'b0;
            ev         = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    res.event_res  = ev;
    res.time_valid = time_valid;
    res.hour       = time_valid ? held_hour : 5'd0;
    res.minute     = time_valid ? held_minute[5:0] : 6'd0;
    res.second     = time_valid ? held_second[5:0] : 6'd0;
    res.frame      = time_valid ? held_frame[4:0] : 5'd0;
    res.rate_type  = time_valid ? held_rate : 2'd0;
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch, got 0x%0h expected 0x%0h", $time, field, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t fresh;
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        nib[i] = 4'd0;
      end
      prev_nib      = NIB_FIRST;
      prev_seen     = 1'b0;
      time_valid    = 1'b0;
      moving        = 1'b0;
      forward       = 1'b0;
      last_frame_us = 32'd0;
      held_hour     = 5'd0;
      held_minute   = 7'd0;
      held_second   = 7'd0;
      held_frame    = 7'd0;
      held_rate     = 2'd0;
      timeout_us    = SYNC_TIMEOUT_RESET;
      awaited_results.delete();
    end else begin
      if (cfg_wr_en) begin
        timeout_us = cfg_wr_data;
      end
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result transfer", 32'(out_data), 32'd0);
        end else begin
          want = awaited_results.pop_front();
          if (out_data.event_res !== want.event_res)
            report_mismatch("event_res", 32'(out_data.event_res), 32'(want.event_res));
          if (out_data.time_valid !== want.time_valid)
            report_mismatch("time_valid", 32'(out_data.time_valid), 32'(want.time_valid));
          if (out_data.hour !== want.hour)
            report_mismatch("hour", 32'(out_data.hour), 32'(want.hour));
          if (out_data.minute !== want.minute)
            report_mismatch("minute", 32'(out_data.minute), 32'(want.minute));
          if (out_data.second !== want.second)
            report_mismatch("second", 32'(out_data.second), 32'(want.second));
          if (out_data.frame !== want.frame)
            report_mismatch("frame", 32'(out_data.frame), 32'(want.frame));
          if (out_data.rate_type !== want.rate_type)
            report_mismatch("rate_type", 32'(out_data.rate_type), 32'(want.rate_type));
        end
      end
      if (in_valid && !in_stall) begin
        advance_timecode(in_data, fresh);
        awaited_results.push_back(fresh);
      end
    end
    results_awaited = awaited_results.size();
  end

endmodule

### sim/midi_timecode_quarter_frame_parser_test.sv
module midi_timecode_quarter_frame_parser_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mtcqf_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int         LONG_HOLD  = 150;
  localparam int         FIRST_RUN  = 220;
  localparam int         PHASE_RUN  = 160;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  int          fail_count;
  int          awaited;

  logic [31:0] clock_us;
  logic [31:0] frame_stamp_us;
  logic [31:0] timeout_now;
  logic        gaps_on;
  int          items_sent;
  int          holds_asked;
  int          holds_done;

  midi_timecode_quarter_frame_parser u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  mtc_timecode_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .mismatch_count  (fail_count),
    .results_awaited (awaited)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic in_item_t scrambled_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  task automatic send(input in_item_t it);
    int gap;
    int r;
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else if (r < 98) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_quarter(input logic [2:0] n, input logic [3:0] v);
    in_item_t it;
    it = scrambled_item();
    it.req_type    = REQ_QUARTER;
    it.qf_byte     = {n, v};
    it.stamp_us    = clock_us;
    frame_stamp_us = clock_us;
    clock_us      += $urandom_range(0, 4000);
    send(it);
  endtask

  task automatic send_full(input logic [6:0] hb, input logic [6:0] m,
                           input logic [6:0] s, input logic [6:0] f);
    in_item_t it;
    it = scrambled_item();
    it.req_type       = REQ_FULL;
    it.full_hour_byte = hb;
    it.full_minute    = m;
    it.full_second    = s;
    it.full_frame     = f;
    it.stamp_us       = clock_us;
    frame_stamp_us    = clock_us;
    clock_us         += $urandom_range(0, 4000);
    send(it);
  endtask

  task automatic send_poll(input logic [31:0] delta);
    in_item_t it;
    it = scrambled_item();
    it.req_type = REQ_POLL;
    it.stamp_us = frame_stamp_us + delta;
    clock_us    = it.stamp_us;
    send(it);
  endtask

  task automatic pick_time(output logic [6:0] hb, output logic [6:0] m,
                           output logic [6:0] s, output logic [6:0] f);
    logic [1:0] rate;
    int         fps;
    rate = 2'($urandom);
    fps  = (rate == RATE_24) ? 24 : (rate == RATE_25) ? 25 : 30;
    hb   = {rate, 5'($urandom_range(0, 23))};
    m    = 7'($urandom_range(0, 59));
    s    = 7'($urandom_range(0, 59));
    f    = 7'($urandom_range(0, fps - 1));
  endtask

  task automatic random_burst();
    int              kind;
    int              len;
    logic [2:0]      n;
    logic            go_fwd;
    logic [6:0]      hb, m, s, f;
    logic [7:0][3:0] nibs;
    in_item_t        it;
    kind    = $urandom_range(0, 99);
    gaps_on = ($urandom_range(0, 4) != 0);
    if ($urandom_range(0, 19) == 0) clock_us += $urandom;
    if (kind < 45) begin
      // A run of quarter frames that spells out one valid time, mostly intact.
      pick_time(hb, m, s, f);
      nibs = {{1'b0, hb[6:5], hb[4]}, hb[3:0], {1'b0, m[6:4]}, m[3:0],
              {1'b0, s[6:4]}, s[3:0], {1'b0, f[6:4]}, f[3:0]};
      go_fwd = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 3) == 0) n = 3'($urandom);
      else n = go_fwd ? 3'd0 : 3'd7;
      len = $urandom_range(3, 17);
      for (int k = 0; k < len; k++) begin
        send_quarter(n, ($urandom_range(0, 9) == 0) ? 4'($urandom) : nibs[n]);
        n = go_fwd ? n + 3'd1 : n - 3'd1;
      end
    end else if (kind < 60) begin
      if ($urandom_range(0, 4) == 0) begin
        hb = 7'($urandom);
        m  = 7'($urandom);
        s  = 7'($urandom);
        f  = 7'($urandom);
      end else begin
        pick_time(hb, m, s, f);
      end
      send_full(hb, m, s, f);
    end else if (kind < 80) begin
      case ($urandom_range(0, 4))
        0:       send_poll(timeout_now - 32'd1);
        1:       send_poll(timeout_now);
        2:       send_poll(timeout_now + 32'd1);
        3:       send_poll($urandom);
        default: send_poll($urandom_range(0, 4000));
      endcase
    end else if (kind < 92) begin
      len = $urandom_range(2, 6);
      for (int k = 0; k < len; k++) begin
        send_quarter(3'($urandom), 4'($urandom));
      end
    end else begin
      it       = scrambled_item();
      clock_us = it.stamp_us;
      if (it.req_type == REQ_QUARTER || it.req_type == REQ_FULL) begin
        frame_stamp_us = it.stamp_us;
      end
      send(it);
    end
  endtask

  // The receiver alternates quiet stretches, short stalls and a few long ones.
  initial begin
    int   run_left;
    int   r;
    int   hold_cycles;
    logic run_stall;
    out_stall  = 1'b0;
    holds_done = 0;
    run_left   = 0;
    run_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        out_stall <= 1'b1;
        for (hold_cycles = 1; hold_cycles < LONG_HOLD; hold_cycles++) @(negedge clk);
      end else begin
        if (run_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 10) begin
            run_stall = 1'b0;
            run_left  = $urandom_range(50, 200);
          end else if (r < 55) begin
            run_stall = 1'b0;
            run_left  = $urandom_range(1, 4);
          end else if (r < 95) begin
            run_stall = 1'b1;
            run_left  = $urandom_range(1, 3);
          end else begin
            run_stall = 1'b1;
            run_left  = $urandom_range(10, 40);
          end
        end
        out_stall <= run_stall;
        run_left--;
      end
    end
  end

  initial begin
    logic [31:0]     settings [5];
    logic [7:0][3:0] top_nibs;
    in_item_t        it;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = 32'd0;
    clock_us       = 32'd100;
    frame_stamp_us = 32'd0;
    timeout_now    = SYNC_TIMEOUT_RESET;
    gaps_on        = 1'b1;
    items_sent     = 0;
    holds_asked    = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A poll with no valid time and the unused request type change nothing.
    send_poll(32'hFFFF_0000);
    it          = scrambled_item();
    it.req_type = REQ_UNUSED;
    send(it);

    // 23:59:59:29 at 30 fps, sent forward, then backward, then a repeat.
    top_nibs = 32'h773B_3B1D;
    for (int k = 0; k < 8; k++) begin
      send_quarter(3'(k), top_nibs[k]);
    end
    for (int k = 6; k >= 0; k--) begin
      send_quarter(3'(k), top_nibs[k]);
    end
    send_quarter(3'd0, top_nibs[0]);

    // Stamps that wrap, and polls on both sides of the timeout.
    clock_us = 32'hFFFF_FF00;
    send_full({RATE_24, 5'd0}, 7'd0, 7'd0, 7'd0);
    send_poll(32'h110);
    send_poll(SYNC_TIMEOUT_RESET);
    send_poll(SYNC_TIMEOUT_RESET + 32'd1);

    send_full({RATE_25, 5'd24}, 7'd10, 7'd20, 7'd5);
    send_full({RATE_24, 5'd1}, 7'd10, 7'd20, 7'd24);
    send_full({RATE_25, 5'd1}, 7'd10, 7'd20, 7'd24);
    send_full(7'h7F, 7'h7F, 7'h7F, 7'h7F);
    send_full({RATE_30DF, 5'd12}, 7'd34, 7'd56, 7'd29);
    send_quarter(3'd5, 4'd3);
    send_quarter(3'd2, 4'd8);
    send_full({RATE_30, 5'd5}, 7'd60, 7'd0, 7'd0);
    send_full({RATE_30, 5'd5}, 7'd0, 7'd60, 7'd0);

    while (items_sent < FIRST_RUN) random_burst();

    settings = '{32'd0, 32'hFFFF_FFFF, 32'd1000, $urandom, $urandom_range(1, 50000)};
    for (int phase = 0; phase < 5; phase++) begin
      in_valid <= 1'b0;
      while (awaited != 0) @(negedge clk);
      repeat (4) @(negedge clk);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= settings[phase];
      timeout_now  = settings[phase];
      @(negedge clk);
      cfg_wr_en <= 1'b0;
      if (phase == 1) holds_asked++;
      while (items_sent < FIRST_RUN + PHASE_RUN * (phase + 1)) random_burst();
    end

    in_valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### midi_timecode_quarter_frame_parser.f
+incdir+hdl
hdl/mtcqf_pkg.sv
hdl/mtcqf_step.sv
hdl/midi_timecode_quarter_frame_parser.sv
hdl/mtcqf_checker.sv
sim/mtc_timecode_checker.sv
sim/midi_timecode_quarter_frame_parser_test.sv
